>>> hdl/ttrd_pkg.sv
package ttrd_pkg;

    // Field widths
    localparam int WORD_W     = 16;
    localparam int ID_W       = 7;
    localparam int DATA_W     = 8;
    localparam int STEP_W     = 21;
    localparam int WRAP_W     = 32;
    localparam int MACRO_W    = 48;
    localparam int WRAP_SHIFT = 16;
    localparam int ENTRY_W    = ID_W + DATA_W;

    // Word codes
    localparam logic [WORD_W-1:0] FILLER_WORD  = 16'h7FFF;
    localparam logic [ID_W-1:0]   ID_LASER     = 7'd124;
    localparam logic [ID_W-1:0]   ID_STEP_LOW  = 7'd125;
    localparam logic [ID_W-1:0]   ID_STEP_MID  = 7'd126;
    localparam logic [ID_W-1:0]   ID_STEP_HIGH = 7'd127;

    // Marker kinds
    localparam logic [ID_W-1:0] MARK_PIXEL = 7'd1;
    localparam logic [ID_W-1:0] MARK_LINE  = 7'd2;
    localparam logic [ID_W-1:0] MARK_FRAME = 7'd3;

    // Configuration register indexes and reset values
    localparam logic            CFG_CHANNEL_COUNT   = 1'b0;
    localparam logic            CFG_DROP_FILLER     = 1'b1;
    localparam logic [ID_W-1:0] CHANNEL_COUNT_RESET = 7'd25;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_MACRO,
        ST_READ,
        ST_PHOTON,
        ST_MARKER
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic s_ready;
        logic wrap_upd;
        logic macro_upd;
        logic rd_en;
        logic load_photon;
        logic load_marker;
        logic done;
    } cmd_t;

    // Datapath to controller; mask bits: [0] pixel, [1] line, [2] frame
    typedef struct packed {
        logic       in_closing;
        logic       fill_zero;
        logic       rd_last;
        logic [2:0] mask;
        logic       mask_single;
        logic       out_free;
    } status_t;

endpackage

>>> hdl/ttrd_ctrl.sv
module ttrd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  ttrd_pkg::status_t status,
    output ttrd_pkg::cmd_t    cmd
);
    import ttrd_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.s_ready = 1'b1;
                if (status.in_closing) begin
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP: begin
                cmd.wrap_upd = 1'b1;
                state_next   = ST_MACRO;
            end
            ST_MACRO: begin
                cmd.macro_upd = 1'b1;
                if (!status.fill_zero) begin
                    state_next = ST_READ;
                end else if (status.mask != 3'b000) begin
                    state_next = ST_MARKER;
                end else begin
                    cmd.done   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_PHOTON;
            end
            ST_PHOTON: begin
                if (status.out_free) begin
                    cmd.load_photon = 1'b1;
                    if (!status.rd_last) begin
                        state_next = ST_READ;
                    end else if (status.mask != 3'b000) begin
                        state_next = ST_MARKER;
                    end else begin
                        cmd.done   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MARKER: begin
                if (status.out_free) begin
                    cmd.load_marker = 1'b1;
                    if (status.mask_single) begin
                        cmd.done   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/ttrd_datapath.sv
module ttrd_datapath #(
    parameter int PENDING_DEPTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic [ttrd_pkg::WORD_W-1:0]   s_word,
    input  logic                          cfg_valid,
    input  logic                          cfg_index,
    input  logic [ttrd_pkg::ID_W-1:0]     cfg_data,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic [ttrd_pkg::MACRO_W-1:0]  m_macro_time,
    output logic [ttrd_pkg::DATA_W-1:0]   m_micro_time,
    output logic [ttrd_pkg::ID_W-1:0]     m_channel,
    output logic                          m_is_marker,
    output logic                          m_overflow,
    output logic                          m_last,
    input  ttrd_pkg::cmd_t                cmd,
    output ttrd_pkg::status_t             status
);
    import ttrd_pkg::*;

    localparam int FILL_W = $clog2(PENDING_DEPTH + 1);
    localparam int IDX_W  = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

    // Configuration
    logic [ID_W-1:0]    chan_count_reg;
    logic               skip_filler_reg;

    // Record state
    logic [STEP_W-1:0]  prev_step_reg;
    logic               step_seen_reg;
    logic [WRAP_W-1:0]  wrap_reg;
    logic [DATA_W-1:0]  low_reg;
    logic [DATA_W-1:0]  mid_reg;
    logic [DATA_W-1:0]  hi_reg;
    logic [DATA_W-1:0]  laser_ref_reg;
    logic               laser_present_reg;
    logic               prev_frame_reg;
    logic               prev_line_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic               lost_reg;
    logic [FILL_W-1:0]  rd_idx_reg;
    logic [2:0]         mask_reg;
    logic               ovf_reg;
    logic [MACRO_W-1:0] macro_reg;
    logic               m_valid_reg;

    // Photon buffer
    logic [ENTRY_W-1:0] buf_mem [PENDING_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic               accept;
    logic               in_flag;
    logic [ID_W-1:0]    in_id;
    logic [DATA_W-1:0]  in_data;
    logic               is_filler;
    logic               is_chan;
    logic               is_closing;
    logic               buf_full;
    logic               buf_wr;
    logic [STEP_W-1:0]  step_w;
    logic [MACRO_W:0]   macro_sum;
    logic [2:0]         mask_clr;
    logic [DATA_W-1:0]  entry_code;
    logic [DATA_W-1:0]  photon_micro;
    logic [ID_W-1:0]    marker_kind;

    // Word decode
    assign accept     = s_valid & cmd.s_ready;
    assign in_flag    = s_word[WORD_W-1];
    assign in_id      = s_word[WORD_W-2:DATA_W];
    assign in_data    = s_word[DATA_W-1:0];
    assign is_filler  = skip_filler_reg && (s_word == FILLER_WORD);
    assign is_chan    = !is_filler && (in_id < chan_count_reg);
    assign is_closing = !is_filler && !is_chan && (in_id == ID_STEP_HIGH);
    assign buf_full   = (fill_reg >= FILL_W'(PENDING_DEPTH));
    assign buf_wr     = accept && is_chan && in_flag && !buf_full;

    // Coarse step and saturated unwrapped time
    assign step_w    = {hi_reg[ID_W-1:0], mid_reg[ID_W-1:0], low_reg[ID_W-1:0]};
    assign macro_sum = {1'b0, wrap_reg, {WRAP_SHIFT{1'b0}}} + (MACRO_W + 1)'(step_w);

    // Marker selection: lowest pending kind first
    assign mask_clr = mask_reg & (mask_reg - 3'b001);
    always_comb begin
        if (mask_reg[0]) begin
            marker_kind = MARK_PIXEL;
        end else if (mask_reg[1]) begin
            marker_kind = MARK_LINE;
        end else begin
            marker_kind = MARK_FRAME;
        end
    end

    // Laser-relative code, wraps modulo 256
    assign entry_code   = rd_data_reg[DATA_W-1:0];
    assign photon_micro = laser_present_reg ? (entry_code - laser_ref_reg) : entry_code;

    // Status to controller
    assign status.in_closing  = s_valid && is_closing;
    assign status.fill_zero   = (fill_reg == '0);
    assign status.rd_last     = (FILL_W'(rd_idx_reg + 1'b1) == fill_reg);
    assign status.mask        = mask_reg;
    assign status.mask_single = (mask_clr == 3'b000);
    assign status.out_free    = !m_valid_reg || m_ready;

    // Configuration and record state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_count_reg    <= CHANNEL_COUNT_RESET;
            skip_filler_reg   <= 1'b1;
            prev_step_reg     <= '0;
            step_seen_reg     <= 1'b0;
            wrap_reg          <= '0;
            low_reg           <= '0;
            mid_reg           <= '0;
            hi_reg            <= '0;
            laser_ref_reg     <= '0;
            laser_present_reg <= 1'b0;
            prev_frame_reg    <= 1'b0;
            prev_line_reg     <= 1'b0;
            fill_reg          <= '0;
            lost_reg          <= 1'b0;
            rd_idx_reg        <= '0;
            mask_reg          <= '0;
            ovf_reg           <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == CFG_CHANNEL_COUNT) begin
                    chan_count_reg <= cfg_data;
                end else begin
                    skip_filler_reg <= cfg_data[0];
                end
            end

            // Input word
            if (accept && !is_filler) begin
                if (is_chan) begin
                    if (in_flag) begin
                        if (!buf_full) begin
                            fill_reg <= fill_reg + 1'b1;
                        end else begin
                            lost_reg <= 1'b1;
                        end
                    end
                end else if (in_id == ID_LASER) begin
                    if (in_flag) begin
                        laser_ref_reg     <= in_data;
                        laser_present_reg <= 1'b1;
                    end
                end else if (in_id == ID_STEP_LOW) begin
                    low_reg <= in_data;
                end else if (in_id == ID_STEP_MID) begin
                    mid_reg <= in_data;
                end else if (in_id == ID_STEP_HIGH) begin
                    hi_reg <= in_data;
                end
            end

            // Unwrap on any decrease; markers from levels and rising edges
            if (cmd.wrap_upd) begin
                if (step_seen_reg && (step_w < prev_step_reg) && (wrap_reg != '1)) begin
                    wrap_reg <= wrap_reg + 1'b1;
                end
                prev_step_reg  <= step_w;
                step_seen_reg  <= 1'b1;
                mask_reg       <= {mid_reg[DATA_W-1] & !prev_frame_reg,
                                   hi_reg[DATA_W-1] & !prev_line_reg,
                                   low_reg[DATA_W-1]};
                prev_frame_reg <= mid_reg[DATA_W-1];
                prev_line_reg  <= hi_reg[DATA_W-1];
                ovf_reg        <= lost_reg;
            end

            if (cmd.macro_upd) begin
                rd_idx_reg <= '0;
            end else if (cmd.load_photon) begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end

            if (cmd.load_marker) begin
                mask_reg <= mask_clr;
            end

            // Record closed
            if (cmd.done) begin
                fill_reg          <= '0;
                lost_reg          <= 1'b0;
                laser_present_reg <= 1'b0;
            end
        end
    end

    // Time of the record
    always_ff @(posedge aclk) begin
        if (cmd.macro_upd) begin
            macro_reg <= macro_sum[MACRO_W] ? '1 : macro_sum[MACRO_W-1:0];
        end
    end

    // Photon buffer write and registered read
    always_ff @(posedge aclk) begin
        if (buf_wr) begin
            buf_mem[fill_reg[IDX_W-1:0]] <= {in_id, in_data};
        end
        if (cmd.rd_en) begin
            rd_data_reg <= buf_mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    // Output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_photon || cmd.load_marker) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge aclk) begin
        if (cmd.load_photon) begin
            m_macro_time <= macro_reg;
            m_micro_time <= photon_micro;
            m_channel    <= rd_data_reg[ENTRY_W-1:DATA_W];
            m_is_marker  <= 1'b0;
            m_overflow   <= ovf_reg;
            m_last       <= status.rd_last && (mask_reg == 3'b000);
        end else if (cmd.load_marker) begin
            m_macro_time <= macro_reg;
            m_micro_time <= '0;
            m_channel    <= marker_kind;
            m_is_marker  <= 1'b1;
            m_overflow   <= ovf_reg;
            m_last       <= (mask_clr == 3'b000);
        end
    end

    assign m_valid = m_valid_reg;

endmodule

>>> hdl/ttr_word_stream_event_decoder.sv
// Time-tagger word stream decoder.
// Input channel (s_valid/s_ready, s_word): one 16-bit tagger word per transfer.
// Detector words are buffered, laser and step words update record state; the
// closing step word (id 127) flushes the record as result transfers on the
// output channel (m_valid/m_ready): buffered photons in arrival order, then the
// pixel, line and frame markers. m_last marks the final result of a record.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0
// is channel_count, index 1 is drop_filler_words; write only while idle.
// A non-closing word is taken without dropping s_ready. A closing word holds
// s_ready low while the record is flushed: step unwrap, time sum, then one
// buffer read and one output load per photon through the single registered
// buffer read port, then one output load per marker, longer when the
// receiver stalls. The first result is loaded after the time sum and the
// first buffer read, or straight after the time sum with no photons.
// A stalled receiver holds the output register and the sequencer waits;
// s_ready returns once the last result of the record is loaded.
// Reset (aresetn, synchronous, active low) clears m_valid and the record
// state but macro_reg, and restores channel_count 25 and drop_filler_words 1.
module ttr_word_stream_event_decoder #(
    parameter int PENDING_DEPTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ttrd_pkg::WORD_W-1:0]   s_word,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [ttrd_pkg::ID_W-1:0]     cfg_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ttrd_pkg::MACRO_W-1:0]  m_macro_time,
    output logic [ttrd_pkg::DATA_W-1:0]   m_micro_time,
    output logic [ttrd_pkg::ID_W-1:0]     m_channel,
    output logic                          m_is_marker,
    output logic                          m_overflow,
    output logic                          m_last
);
    import ttrd_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Configuration writes are taken in any cycle
    assign cfg_ready = 1'b1;
    assign s_ready   = cmd.s_ready;

    ttrd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .cmd     (cmd)
    );

    ttrd_datapath #(
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_word       (s_word),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_macro_time (m_macro_time),
        .m_micro_time (m_micro_time),
        .m_channel    (m_channel),
        .m_is_marker  (m_is_marker),
        .m_overflow   (m_overflow),
        .m_last       (m_last),
        .cmd          (cmd),
        .status       (status)
    );

    // A closing word blocks further input until the record is flushed
    a_close_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && status.in_closing |=> !s_ready)
        else $error("input taken right after a closing word");

    // Results are loaded only into a free output register
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_photon || cmd.load_marker) |-> status.out_free)
        else $error("result loaded over a pending result");

    // Closing a record empties the photon buffer
    a_done_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.done |=> status.fill_zero)
        else $error("photon buffer not empty after record close");

endmodule
